// File: rtl/integer_to_ascii_formatter_core_macros.svh
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core_macros.svh
// Assertion helpers for the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_CORE_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define ITAF_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while in reset.
`define ITAF_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Shared types, codes and helpers of the integer-to-ASCII formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

  localparam int unsigned VALUE_W  = 64;
  localparam int unsigned NDIGITS  = 20;               // decimal digits of 2^64-1
  localparam int unsigned DIG_W    = 4 * NDIGITS;      // digit buffer width
  localparam int unsigned DCNT_W   = 5;                // holds NDIGITS
  localparam int unsigned STEP_W   = 6;                // counts VALUE_W steps

  localparam logic [DCNT_W-1:0] DCNT_FULL = DCNT_W'(NDIGITS);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(VALUE_W - 1);

  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_MINUS = 8'h2d;
  localparam logic [7:0] CHAR_UC_A  = 8'h41;
  localparam logic [7:0] CHAR_LC_A  = 8'h61;

  typedef enum logic [1:0] {
    OP_DEC   = 2'd0,
    OP_HEX32 = 2'd1,
    OP_HEX64 = 2'd2,
    OP_RSVD  = 2'd3   // treated as OP_HEX64
  } opcode_t;

  typedef struct packed {
    opcode_t            opcode;
    logic [VALUE_W-1:0] value;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_word_t;

  // controller -> datapath
  typedef struct packed {
    logic load;
    logic conv_step;
    logic shift_digit;
    logic emit_minus;
    logic emit_digit;
    logic last;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic top_zero;
  } dp_status_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib, input logic upper);
    logic [7:0] code;
    if (nib < 4'd10) begin
      code = CHAR_ZERO + 8'(nib);
    end else begin
      code = (upper ? CHAR_UC_A : CHAR_LC_A) + 8'(nib - 4'd10);
    end
    return code;
  endfunction

endpackage

// File: rtl/integer_to_ascii_formatter_core.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_core
// Formats a 64-bit integer as ASCII: signed decimal, 32-bit or 64-bit hex.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive in_word (opcode, value) and raise start; the word is taken
//   at a clock edge where start is high and busy is low. busy stays high
//   until the last character has been handed to the output register.
//   Output: one character per out_strobe pulse, most significant first, with
//   out_word.last set on the final one. Each pulse lasts one cycle; the
//   receiver cannot stall, so it must take every character as it comes.
//   Config: cfg_data (hex upper case) is written when cfg_valid is high;
//   cfg_ready is always high. Write only while busy is low and no output
//   is pending.
//   Timing: a negative decimal first emits a minus sign; decimal then runs
//   the shift-add-3 conversion over all 64 bits (one bit per cycle); hex
//   skips conversion. Then leading zeros are dropped one digit per cycle,
//   always keeping the last digit, and the remaining digits are emitted one
//   per cycle. The final character appears in the same cycle as busy goes
//   low.
//   Reset: synchronous rst_n returns the sequencer to idle, drops the
//   strobe and clears the hex case bit to lower case.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_core_macros.svh"

module integer_to_ascii_formatter_core (
  input  logic                 clk,
  input  logic                 rst_n,
  // input channel
  input  logic                 start,
  output logic                 busy,
  input  itaf_pkg::in_word_t   in_word,
  // result channel
  output logic                 out_strobe,
  output itaf_pkg::out_word_t  out_word,
  // configuration
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic                 cfg_data
);

  itaf_pkg::dp_cmd_t    cmd;
  itaf_pkg::dp_status_t status;
  logic                 hex_upper_r;
  logic                 is_dec;

  // writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hex_upper_r <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      hex_upper_r <= cfg_data;
    end
  end

  assign is_dec = (in_word.opcode == itaf_pkg::OP_DEC);

  // sequencer
  itaf_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .is_dec (is_dec),
    .is_neg (in_word.value[itaf_pkg::VALUE_W-1]),
    .status (status),
    .cmd    (cmd),
    .busy   (busy)
  );

  // conversion and output registers
  itaf_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_word    (in_word),
    .hex_upper  (hex_upper_r),
    .cmd        (cmd),
    .status     (status),
    .out_strobe (out_strobe),
    .out_word   (out_word)
  );

  // accepted word keeps the block busy
  `ITAF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
  // the final character appears while the sequencer is idle
  `ITAF_ASSERT_SAME(a_last_idle, out_strobe && out_word.last, !busy,
                    "last character while still busy")
  // a minus sign is never the final character
  `ITAF_ASSERT_SAME(a_minus_not_last, out_strobe && (out_word.char_code == itaf_pkg::CHAR_MINUS),
                    !out_word.last, "minus sign marked last")

endmodule

// File: rtl/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: sign, binary-to-BCD steps, leading-zero skip, digit emission.
// ----------------------------------------------------------------------------
module itaf_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  input  logic                 is_dec,
  input  logic                 is_neg,
  input  itaf_pkg::dp_status_t status,
  output itaf_pkg::dp_cmd_t    cmd,
  output logic                 busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SIGN,
    ST_CONV,
    ST_SKIP,
    ST_EMIT
  } state_t;

  state_t                          state_r, state_nxt;
  logic [itaf_pkg::STEP_W-1:0]     step_r, step_nxt;
  logic [itaf_pkg::DCNT_W-1:0]     dcnt_r, dcnt_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    dcnt_nxt  = dcnt_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          step_nxt = '0;
          dcnt_nxt = itaf_pkg::DCNT_FULL;
          if (is_dec) begin
            state_nxt = is_neg ? ST_SIGN : ST_CONV;
          end else begin
            state_nxt = ST_SKIP;
          end
        end
      end
      ST_SIGN: begin
        cmd.emit_minus = 1'b1;
        state_nxt      = ST_CONV;
      end
      ST_CONV: begin
        cmd.conv_step = 1'b1;
        step_nxt      = step_r + 1'b1;
        if (step_r == itaf_pkg::STEP_LAST) begin
          state_nxt = ST_SKIP;
        end
      end
      ST_SKIP: begin
        // drop one leading zero per cycle, always keep the last digit
        if (status.top_zero && (dcnt_r > itaf_pkg::DCNT_W'(1))) begin
          cmd.shift_digit = 1'b1;
          dcnt_nxt        = dcnt_r - 1'b1;
        end else begin
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit_digit  = 1'b1;
        cmd.shift_digit = 1'b1;
        cmd.last        = (dcnt_r == itaf_pkg::DCNT_W'(1));
        dcnt_nxt        = dcnt_r - 1'b1;
        if (dcnt_r == itaf_pkg::DCNT_W'(1)) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      step_r  <= '0;
      dcnt_r  <= '0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      dcnt_r  <= dcnt_nxt;
    end
  end

endmodule

// File: rtl/itaf_dp.sv
// ----------------------------------------------------------------------------
// itaf_dp
// Datapath: magnitude load, shift-add-3 BCD conversion, digit shifter and
// output word register.
// ----------------------------------------------------------------------------
module itaf_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  itaf_pkg::in_word_t    in_word,
  input  logic                  hex_upper,
  input  itaf_pkg::dp_cmd_t     cmd,
  output itaf_pkg::dp_status_t  status,
  output logic                  out_strobe,
  output itaf_pkg::out_word_t   out_word
);

  logic [itaf_pkg::VALUE_W-1:0] bin_r, bin_nxt;
  logic [itaf_pkg::DIG_W-1:0]   dig_r, dig_nxt;
  logic [itaf_pkg::DIG_W-1:0]   adj;
  logic [itaf_pkg::VALUE_W-1:0] mag;
  logic [3:0]                   top_dig;
  logic                         out_strobe_r;
  itaf_pkg::out_word_t          out_word_r;

  assign top_dig         = dig_r[itaf_pkg::DIG_W-1 -: 4];
  assign status.top_zero = (top_dig == 4'd0);

  // two's complement magnitude; the most negative value maps to 2^63
  assign mag = in_word.value[itaf_pkg::VALUE_W-1] ? (~in_word.value + 1'b1) : in_word.value;

  // add 3 to every BCD digit of 5 or more
  always_comb begin
    for (int i = 0; i < itaf_pkg::NDIGITS; i++) begin
      adj[4*i +: 4] = (dig_r[4*i +: 4] >= 4'd5) ? (dig_r[4*i +: 4] + 4'd3) : dig_r[4*i +: 4];
    end
  end

  always_comb begin
    bin_nxt = bin_r;
    dig_nxt = dig_r;
    if (cmd.load) begin
      case (in_word.opcode)
        itaf_pkg::OP_DEC: begin
          bin_nxt = mag;
          dig_nxt = '0;
        end
        itaf_pkg::OP_HEX32: begin
          dig_nxt = itaf_pkg::DIG_W'(in_word.value[31:0]);
        end
        default: begin
          dig_nxt = itaf_pkg::DIG_W'(in_word.value);
        end
      endcase
    end else if (cmd.conv_step) begin
      dig_nxt = {adj[itaf_pkg::DIG_W-2:0], bin_r[itaf_pkg::VALUE_W-1]};
      bin_nxt = {bin_r[itaf_pkg::VALUE_W-2:0], 1'b0};
    end else if (cmd.shift_digit) begin
      dig_nxt = {dig_r[itaf_pkg::DIG_W-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    bin_r <= bin_nxt;
    dig_r <= dig_nxt;
    out_word_r.char_code <= cmd.emit_minus ? itaf_pkg::CHAR_MINUS
                                           : itaf_pkg::digit_char(top_dig, hex_upper);
    out_word_r.last      <= cmd.last;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit_minus | cmd.emit_digit;
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_word   = out_word_r;

endmodule
